>>> design/rpep_pkg.sv
package rpep_pkg;

	// Fixed field widths of the sample and result beats.
	localparam int GRAY_W = 8;
	localparam int THR_W = 5;
	localparam int POS_W = 10;
	localparam int MODE_W = 2;

	// Default profile length limit, in samples after the reference.
	localparam int DEF_MAX_STEPS = 256;

	// APB register file geometry.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 4;

	// Register word indexes.
	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_POLARITY  = 2'd1,
		REG_PICK_MODE = 2'd2,
		REG_SUBPIXEL  = 2'd3
	} reg_idx_t;

	// Pick mode codes; any other code picks the strongest edge.
	localparam logic [MODE_W-1:0] PICK_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] PICK_LAST = 2'd1;
	localparam logic [MODE_W-1:0] PICK_STRONGEST = 2'd2;

	// Reset value of the threshold register.
	localparam logic [THR_W-1:0] THRESHOLD_RST = 5'd2;

	typedef struct packed {
		logic [THR_W-1:0]  threshold;
		logic              polarity;
		logic [MODE_W-1:0] pick_mode;
		logic              subpixel;
	} cfg_t;

	typedef struct packed {
		logic              found;
		logic [POS_W-1:0]  position;
		logic [GRAY_W-1:0] strength;
	} result_t;

endpackage

>>> design/rpep_cfg.sv
module rpep_cfg
	import rpep_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	// Register writes complete in the access phase; pready is tied high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RST;
			cfg_q.polarity <= 1'b0;
			cfg_q.pick_mode <= PICK_FIRST;
			cfg_q.subpixel <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_THRESHOLD: cfg_q.threshold <= pwdata[THR_W-1:0];
				REG_POLARITY:  cfg_q.polarity <= pwdata[0];
				REG_PICK_MODE: cfg_q.pick_mode <= pwdata[MODE_W-1:0];
				REG_SUBPIXEL:  cfg_q.subpixel <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux, zero extended to the bus width.
	always_comb begin
		unique case (idx)
			REG_THRESHOLD: prdata = APB_DATA_W'(cfg_q.threshold);
			REG_POLARITY:  prdata = APB_DATA_W'(cfg_q.polarity);
			REG_PICK_MODE: prdata = APB_DATA_W'(cfg_q.pick_mode);
			REG_SUBPIXEL:  prdata = APB_DATA_W'(cfg_q.subpixel);
			default:       prdata = '0;
		endcase
	end

endmodule

>>> design/rpep_core.sv
module rpep_core
	import rpep_pkg::*;
#(
	parameter int MAX_STEPS = DEF_MAX_STEPS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              beat,
	input  logic [GRAY_W-1:0] gray_value,
	input  logic              inside_image,
	input  logic              profile_end,
	input  cfg_t              cfg,
	output logic              res_valid,
	output result_t           res
);

	localparam int STEP_W = $clog2(MAX_STEPS + 1);
	localparam int PX_W = (STEP_W + 1 > POS_W) ? STEP_W + 1 : POS_W;

	// Profile state.
	logic              active_q;
	logic              skipped_q;
	logic [GRAY_W-1:0] ref_q;
	logic [STEP_W-1:0] step_q;
	logic              picked_q;
	logic              locked_q;
	logic [GRAY_W-1:0] best_str_q;
	logic [POS_W-1:0]  best_pos_q;

	logic              active_d;
	logic              skipped_d;
	logic [GRAY_W-1:0] ref_d;
	logic [STEP_W-1:0] step_d;
	logic              picked_d;
	logic              locked_d;
	logic [GRAY_W-1:0] best_str_d;
	logic [POS_W-1:0]  best_pos_d;

	logic [GRAY_W:0]   diff_up;
	logic [GRAY_W:0]   diff_dn;
	logic              match;
	logic [GRAY_W-1:0] strength;
	logic              half_back;
	logic [PX_W-1:0]   pos_ext;
	logic              counting;
	logic              examine;
	logic              keep;

	// Signed step differences against the reference.
	assign diff_up = {1'b0, gray_value} - {1'b0, ref_q};
	assign diff_dn = {1'b0, ref_q} - {1'b0, gray_value};
	assign match = cfg.polarity
		? ($signed(diff_dn) >= $signed({{(GRAY_W + 1 - THR_W){1'b0}}, cfg.threshold}))
		: ($signed(diff_up) >= $signed({{(GRAY_W + 1 - THR_W){1'b0}}, cfg.threshold}));
	assign strength = diff_up[GRAY_W] ? diff_dn[GRAY_W-1:0] : diff_up[GRAY_W-1:0];
	assign half_back = cfg.subpixel && (gray_value != ref_q);

	// Position in half steps, using the step count after this sample.
	assign pos_ext = PX_W'({step_d, 1'b0}) - PX_W'(half_back);

	assign counting = active_q && (step_q < STEP_W'(MAX_STEPS));
	assign examine = counting && !skipped_q && inside_image;

	// Pick rule: first locks, last overwrites, strongest keeps the earliest maximum.
	always_comb begin
		keep = 1'b0;
		if (examine && match && !locked_q) begin
			case (cfg.pick_mode)
				PICK_FIRST: keep = 1'b1;
				PICK_LAST:  keep = 1'b1;
				default:    keep = !picked_q || (strength > best_str_q);
			endcase
		end
	end

	// Next profile state for the current sample.
	always_comb begin
		active_d = active_q;
		skipped_d = skipped_q;
		ref_d = ref_q;
		step_d = step_q;
		picked_d = picked_q;
		locked_d = locked_q;
		best_str_d = best_str_q;
		best_pos_d = best_pos_q;
		if (!active_q) begin
			// Reference sample opens a new profile.
			active_d = 1'b1;
			skipped_d = !inside_image;
			ref_d = inside_image ? gray_value : '0;
			step_d = '0;
			picked_d = 1'b0;
			locked_d = 1'b0;
			best_str_d = '0;
			best_pos_d = '0;
		end else if (counting) begin
			step_d = step_q + 1'b1;
			if (examine) begin
				ref_d = gray_value;
			end
		end
		if (keep) begin
			picked_d = 1'b1;
			best_str_d = strength;
			best_pos_d = pos_ext[POS_W-1:0];
			if (cfg.pick_mode == PICK_FIRST) begin
				locked_d = 1'b1;
			end
		end
	end

	// Result of the closing sample.
	assign res_valid = beat && profile_end;
	assign res.found = picked_d;
	assign res.position = picked_d ? best_pos_d : '0;
	assign res.strength = picked_d ? best_str_d : '0;

	// State update; the closing sample clears the profile.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			skipped_q <= 1'b0;
			ref_q <= '0;
			step_q <= '0;
			picked_q <= 1'b0;
			locked_q <= 1'b0;
			best_str_q <= '0;
			best_pos_q <= '0;
		end else if (beat) begin
			if (profile_end) begin
				active_q <= 1'b0;
				skipped_q <= 1'b0;
				ref_q <= '0;
				step_q <= '0;
				picked_q <= 1'b0;
				locked_q <= 1'b0;
				best_str_q <= '0;
				best_pos_q <= '0;
			end else begin
				active_q <= active_d;
				skipped_q <= skipped_d;
				ref_q <= ref_d;
				step_q <= step_d;
				picked_q <= picked_d;
				locked_q <= locked_d;
				best_str_q <= best_str_d;
				best_pos_q <= best_pos_d;
			end
		end
	end

endmodule

>>> design/radial_profile_edge_picker_top.sv
// Edge picker for one scan profile of gray samples.
// Input channel: one beat per sample (gray_value, inside_image, profile_end),
// taken when in_valid is high and in_stall is low. The first sample of a
// profile is the reference; the beat with profile_end closes the profile.
// Output channel: one beat per profile (edge_found, position_half_steps,
// edge_strength), taken when out_valid is high and out_stall is low.
// Throughput is one sample per cycle while in_stall is low: each sample is
// a single subtract, compare and state update in the profile register set.
// The closing sample's result is registered into the output register, or into
// the skid register while the output register holds a stalled result.
// When the receiver stalls, the result holds in the output register and a
// second result can land in a skid register; in_stall rises only while the
// skid register is full.
// The user must write configuration through the APB port only while no profile is open; the block does not enforce it.
// Reset clears the profile state, empties both output registers and loads
// the register defaults: threshold 2, rising polarity, first pick, no subpixel.
module radial_profile_edge_picker_top
	import rpep_pkg::*;
#(
	parameter int MAX_STEPS = DEF_MAX_STEPS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [GRAY_W-1:0]     gray_value,
	input  logic                  inside_image,
	input  logic                  profile_end,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  edge_found,
	output logic [POS_W-1:0]      position_half_steps,
	output logic [GRAY_W-1:0]     edge_strength,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	cfg_t    cfg;
	logic    beat;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;
	logic    skid_valid_q;
	result_t skid_q;
	logic    out_free;

	assign pready = 1'b1;

	rpep_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	assign in_stall = skid_valid_q;
	assign beat = in_valid && !in_stall;

	rpep_core #(
		.MAX_STEPS(MAX_STEPS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.beat        (beat),
		.gray_value  (gray_value),
		.inside_image(inside_image),
		.profile_end (profile_end),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res)
	);

	// The output register is free when empty or when its beat leaves now.
	assign out_free = !out_valid_q || !out_stall;

	// Output register and skid register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result payloads.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign edge_found = out_q.found;
	assign position_half_steps = out_q.position;
	assign edge_strength = out_q.strength;

endmodule

>>> design/rpep_checker.sv
module rpep_checker
	import rpep_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              profile_end,
	input logic              out_valid,
	input logic              out_stall,
	input logic              edge_found,
	input logic [POS_W-1:0]  position_half_steps,
	input logic [GRAY_W-1:0] edge_strength
);

	// A held result beat stays on the port.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// Input backpressure only follows a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("input stalled without a stalled result");

	// A closing sample with an empty output gives a result next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && profile_end && !out_valid |=> out_valid)
		else $error("closing sample gave no result");

	// A profile with no edge reports zero position and strength.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !edge_found |-> position_half_steps == '0 && edge_strength == '0)
		else $error("empty result carries nonzero fields");

endmodule

bind radial_profile_edge_picker_top rpep_checker u_rpep_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_stall           (in_stall),
	.profile_end        (profile_end),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.edge_found         (edge_found),
	.position_half_steps(position_half_steps),
	.edge_strength      (edge_strength)
);
